[sv/lpc_pkg.sv]
// shared types and constants of the lru page cache
package lpc_pkg;

  localparam int ID_W     = 32;
  localparam int HANDLE_W = 16;
  localparam int CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [ID_W-1:0]     page_id;
    logic [HANDLE_W-1:0] page_handle;
    logic                page_dirty;
  } req_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] handle_out;
    logic                evicted;
    logic                writeback_notice;
    logic [ID_W-1:0]     evicted_id;
    logic [HANDLE_W-1:0] evicted_handle;
  } rsp_t;

endpackage

[sv/lpc_in_reg.sv]
// input register of the lru page cache
module lpc_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  lpc_pkg::req_t req_in,
  input  logic          advance,
  output logic          vld_r,
  output lpc_pkg::req_t req_r
);

  logic vld_nxt;

  assign in_tready = !vld_r || advance;

  always_comb begin
    vld_nxt = vld_r;
    if (in_tready) begin
      vld_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_r <= req_in;
    end
  end

endmodule

[sv/lpc_store.sv]
// entry store with parallel key compare, age ranks and lru replacement
module lpc_store #(
  parameter int ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        upd,
  input  lpc_pkg::req_t               req,
  input  logic [lpc_pkg::CAP_W-1:0]   cap,
  output lpc_pkg::rsp_t               rsp
);

  localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > lpc_pkg::CAP_W) ? CNT_W : lpc_pkg::CAP_W;

  logic [ENTRIES-1:0]                valid_r, valid_nxt;
  logic [lpc_pkg::ID_W-1:0]          key_r    [ENTRIES];
  logic [lpc_pkg::HANDLE_W-1:0]      handle_r [ENTRIES];
  logic [ENTRIES-1:0]                dirty_r;
  logic [AGE_W-1:0]                  age_r    [ENTRIES];
  logic [CNT_W-1:0]                  count_r, count_nxt;

  logic [lpc_pkg::ID_W-1:0]          key_nxt    [ENTRIES];
  logic [lpc_pkg::HANDLE_W-1:0]      handle_nxt [ENTRIES];
  logic [ENTRIES-1:0]                dirty_nxt;
  logic [AGE_W-1:0]                  age_nxt    [ENTRIES];

  logic [CMP_W-1:0]                  cap_ext, cnt_ext, lim;
  logic                              full;
  logic [ENTRIES-1:0]                hit_vec, victim_vec, valid_after, inv, free_oh;
  logic                              any_hit, is_put, evict, have_free, ins;
  logic [AGE_W-1:0]                  hit_age, oldest_age;
  logic [lpc_pkg::HANDLE_W-1:0]      hit_handle, vic_handle;
  logic [lpc_pkg::ID_W-1:0]          vic_key;
  logic                              vic_dirty;

  // effective capacity and fullness
  always_comb begin
    cap_ext = CMP_W'(cap);
    cnt_ext = CMP_W'(count_r);
    if (cap_ext == '0) begin
      lim = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      lim = CMP_W'(ENTRIES);
    end else begin
      lim = cap_ext;
    end
    full = (cnt_ext >= lim) && (count_r != '0);
  end

  // parallel compare and selection
  always_comb begin
    oldest_age = AGE_W'(count_r - CNT_W'(1));
    hit_age    = '0;
    hit_handle = '0;
    vic_handle = '0;
    vic_key    = '0;
    vic_dirty  = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]    = valid_r[i] && (key_r[i] == req.page_id);
      victim_vec[i] = valid_r[i] && (age_r[i] == oldest_age);
      hit_age    = hit_age    | (age_r[i]    & {AGE_W{hit_vec[i]}});
      hit_handle = hit_handle | (handle_r[i] & {lpc_pkg::HANDLE_W{hit_vec[i]}});
      vic_handle = vic_handle | (handle_r[i] & {lpc_pkg::HANDLE_W{victim_vec[i]}});
      vic_key    = vic_key    | (key_r[i]    & {lpc_pkg::ID_W{victim_vec[i]}});
      vic_dirty  = vic_dirty  | (dirty_r[i]  & victim_vec[i]);
    end
    any_hit     = |hit_vec;
    is_put      = (req.mode == lpc_pkg::MODE_PUT);
    evict       = is_put && !any_hit && full;
    valid_after = valid_r & ~(victim_vec & {ENTRIES{evict}});
    inv         = ~valid_after;
    free_oh     = inv & (~inv + ENTRIES'(1));
    have_free   = |inv;
    ins         = is_put && !any_hit && have_free;
  end

  // result fields
  always_comb begin
    rsp.hit              = any_hit;
    rsp.handle_out       = (any_hit && !is_put) ? hit_handle : '0;
    rsp.evicted          = evict;
    rsp.writeback_notice = evict && vic_dirty;
    rsp.evicted_id       = evict ? vic_key : '0;
    rsp.evicted_handle   = evict ? vic_handle : '0;
  end

  // next state of every entry
  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    dirty_nxt = dirty_r;
    for (int i = 0; i < ENTRIES; i++) begin
      key_nxt[i]    = key_r[i];
      handle_nxt[i] = handle_r[i];
      age_nxt[i]    = age_r[i];
      if (any_hit) begin
        if (hit_vec[i]) begin
          age_nxt[i] = '0;
          if (is_put) begin
            handle_nxt[i] = req.page_handle;
            dirty_nxt[i]  = req.page_dirty;
          end
        end else if (valid_r[i] && (age_r[i] < hit_age)) begin
          age_nxt[i] = AGE_W'(age_r[i] + AGE_W'(1));
        end
      end else if (ins) begin
        if (free_oh[i]) begin
          key_nxt[i]    = req.page_id;
          handle_nxt[i] = req.page_handle;
          dirty_nxt[i]  = req.page_dirty;
          age_nxt[i]    = '0;
        end else if (valid_after[i]) begin
          age_nxt[i] = AGE_W'(age_r[i] + AGE_W'(1));
        end
      end
    end
    if (!any_hit && is_put) begin
      valid_nxt = valid_after | (free_oh & {ENTRIES{ins}});
      count_nxt = CNT_W'(count_r - CNT_W'(evict) + CNT_W'(ins));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (upd) begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      dirty_r <= dirty_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        key_r[i]    <= key_nxt[i];
        handle_r[i] <= handle_nxt[i];
        age_r[i]    <= age_nxt[i];
      end
    end
  end

endmodule

[sv/lru_page_cache.sv]
// top level of the lru page cache: ports, capacity register and result register
// Fully associative page cache with least-recently-used replacement. One request
// (get or put) is accepted every clock cycle while the result side keeps up. Its result
// passes through the input register and then the result register before it is offered
// on the output. With the output held off, one result waits in the result register and
// one request in the input register, then in_tready falls. The rate is set by the
// combinational key compare and age-rank update across all ENTRIES slots between those
// two registers. Entries are invalid after reset without any clearing pass.
// The capacity register resets to 16; a value of zero acts as one and a value above
// ENTRIES acts as ENTRIES. Write it only while no request is in flight.
module lru_page_cache #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,  // page_id[31:0], page_handle[47:32], page_dirty[48], zero
  input  logic        in_tuser,  // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata, // hit, handle_out, evicted, writeback_notice,
                                 // evicted_id, evicted_handle, zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  logic [lpc_pkg::CAP_W-1:0] cap_r;
  lpc_pkg::req_t             req_in, req_r;
  lpc_pkg::rsp_t             rsp, rsp_r;
  logic                      vld_r, advance;
  logic                      out_vld_r, out_vld_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lpc_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  assign req_in.mode        = in_tuser;
  assign req_in.page_id     = in_tdata[31:0];
  assign req_in.page_handle = in_tdata[47:32];
  assign req_in.page_dirty  = in_tdata[48];

  assign advance = vld_r && (!out_vld_r || out_tready);

  lpc_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .req_in    (req_in),
    .advance   (advance),
    .vld_r     (vld_r),
    .req_r     (req_r)
  );

  lpc_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (advance),
    .req   (req_r),
    .cap   (cap_r),
    .rsp   (rsp)
  );

  // result register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_r <= rsp;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b0, rsp_r.evicted_handle, rsp_r.evicted_id,
                       rsp_r.writeback_notice, rsp_r.evicted, rsp_r.handle_out, rsp_r.hit};

endmodule
